// ===== rtl/core/tbfem_pkg.sv =====
// Package with shared types and constants of the three-band FIR energy meter.
`timescale 1ns / 1ps
package tbfem_pkg;

  // Default number of filter taps
  localparam int unsigned TAPS_DEF  = 64;
  localparam int unsigned NBANDS    = 3;
  localparam int unsigned QSHIFT    = 15;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned TAP_IDX_W = 6;
  localparam int unsigned ACC_W     = 31;
  localparam int unsigned DEC_W     = 8;
  localparam logic [DEC_W-1:0] DEC_RESET = 8'd4;

  // Action codes
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef logic [NBANDS-1:0][SMP_W-1:0] coef_vec_t;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
    logic [1:0]              band_select;
    logic [TAP_IDX_W-1:0]    tap_index;
    logic signed [SMP_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] band_energy;
    logic [1:0]       energy_band;
  } out_item_t;

  // Control of the cell row
  typedef struct packed {
    logic             push;
    logic             rot;
    logic             wr;
    logic [1:0]       wr_band;
    logic [SMP_W-1:0] wr_coef;
  } cell_ctrl_t;

  // Control of one band datapath
  typedef struct packed {
    logic clr_sum;
    logic mac_en;
    logic add_en;
    logic sqr_en;
    logic acc_en;
    logic rd_clr;
  } band_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SQR,
    ST_ADD
  } state_e;

endpackage

// ===== rtl/core/tbfem_cell.sv =====
// One tap cell: holds a mono sample and the three band coefficients of its tap.
`timescale 1ns / 1ps
module tbfem_cell
  import tbfem_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             sel_i,
  input  logic [SMP_W-1:0] push_smp_i,
  input  logic [SMP_W-1:0] rot_smp_i,
  input  coef_vec_t        rot_coef_i,
  output logic [SMP_W-1:0] smp_o,
  output coef_vec_t        coef_o
);

  logic [SMP_W-1:0] smp_q, smp_d;
  coef_vec_t        coef_q, coef_d;

  // Shift on push, rotate during a filter run, load a coefficient on write
  always_comb begin
    smp_d  = smp_q;
    coef_d = coef_q;
    if (ctrl_i.push) begin
      smp_d = push_smp_i;
    end else if (ctrl_i.rot) begin
      smp_d  = rot_smp_i;
      coef_d = rot_coef_i;
    end else if (ctrl_i.wr && sel_i && (32'(ctrl_i.wr_band) < NBANDS)) begin
      coef_d[ctrl_i.wr_band] = ctrl_i.wr_coef;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q  <= '0;
      coef_q <= '0;
    end else begin
      smp_q  <= smp_d;
      coef_q <= coef_d;
    end
  end

  assign smp_o  = smp_q;
  assign coef_o = coef_q;

endmodule

// ===== rtl/core/tbfem_band.sv =====
// One band datapath: multiply-accumulate, square and saturating energy sum.
`timescale 1ns / 1ps
module tbfem_band
  import tbfem_pkg::*;
#(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  band_ctrl_t       ctrl_i,
  input  logic [SMP_W-1:0] coef_i,
  input  logic [SMP_W-1:0] smp_i,
  output logic [ACC_W-1:0] acc_o
);

  localparam int unsigned PROD_W = 2 * SMP_W;
  localparam int unsigned TERM_W = PROD_W - QSHIFT;
  localparam int unsigned SUM_W  = TERM_W + $clog2(TAPS);
  localparam int unsigned SQ_W   = 2 * SUM_W;
  localparam int unsigned E_W    = SQ_W - QSHIFT;
  localparam int unsigned EXT_W  = ((E_W > ACC_W) ? E_W : ACC_W) + 1;
  localparam logic [EXT_W-1:0] ACC_MAX = {{(EXT_W-ACC_W){1'b0}}, {ACC_W{1'b1}}};

  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [SQ_W-1:0]   sq_full;
  logic [E_W-1:0]           sq_q;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [EXT_W-1:0]         acc_sum;

  // Register the tap product
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mac_en) begin
      prod_q <= $signed(coef_i) * $signed(smp_i);
    end
  end

  // Sum the floor-shifted products
  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clr_sum) begin
      sum_d = '0;
    end else if (ctrl_i.add_en) begin
      sum_d = sum_q + SUM_W'($signed(prod_q[PROD_W-1:QSHIFT]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // Square the band result; it is never negative
  assign sq_full = sum_q * sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sqr_en) begin
      sq_q <= sq_full[SQ_W-1:QSHIFT];
    end
  end

  // Add with saturation, clear on read
  assign acc_sum = EXT_W'(acc_q) + EXT_W'(sq_q);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.rd_clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = (acc_sum > ACC_MAX) ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/core/three_band_fir_energy_meter_unit.sv =====
// Top level of the three-band FIR energy meter: cell row, band datapaths, control.
//
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_data_i  (in_item_t)
// out      output     out_valid_o / out_stall_i out_data_o (out_item_t)
// cfg      input      cfg_we_i                 cfg_wdata_i (decimation factor)
//
// A coefficient write, a read or a push that does not fire the filters leaves
// the control idle. A push that fires them starts a filter run: the accepting
// cycle, a phase in which the cell row rotates once around past one multiplier per
// band, a step to add the last product, then one square and one saturating
// add. Reset clears samples, coefficients, accumulators and the decimation
// count at once. Input stalls while a filter run is active or while a result
// waits on a stalled output.
`timescale 1ns / 1ps
module three_band_fir_energy_meter_unit
  import tbfem_pkg::*;
#(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [DEC_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(TAPS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEC_W-1:0] dec_q, dec_d, dec_inc;
  logic [DEC_W-1:0] factor_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             acc_in, do_push, do_write, do_read, fire;
  logic [SMP_W:0]   mix;
  cell_ctrl_t       cell_ctrl;
  band_ctrl_t       band_ctrl [NBANDS];
  logic [ACC_W-1:0] acc [NBANDS];
  logic [SMP_W-1:0] smp_w [TAPS];
  coef_vec_t        coef_w [TAPS];
  logic [TAPS-1:0]  sel;

  // Accept a transaction only when idle and the output can take a result
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign acc_in     = in_valid_i && !in_stall_o;
  assign do_push    = acc_in && (in_data_i.action == ACT_PUSH);
  assign do_write   = acc_in && (in_data_i.action == ACT_WRITE);
  assign do_read    = acc_in && (in_data_i.action == ACT_READ)
                      && (32'(in_data_i.band_select) < NBANDS);

  // Mix to mono with a floor shift
  assign mix = {in_data_i.left_sample[SMP_W-1], in_data_i.left_sample}
             + {in_data_i.right_sample[SMP_W-1], in_data_i.right_sample};

  // Decimation count
  assign dec_inc = dec_q + DEC_W'(1);
  assign fire    = do_push && (dec_inc >= factor_q);

  always_comb begin
    dec_d = dec_q;
    if (do_push) begin
      dec_d = fire ? '0 : dec_inc;
    end
  end

  // Sequence a filter run
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_SQR;
        end
      end
      ST_SQR: state_d = ST_ADD;
      ST_ADD: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold a read result until taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (do_read) begin
      out_valid_d       = 1'b1;
      out_d.band_energy = acc[in_data_i.band_select];
      out_d.energy_band = in_data_i.band_select;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dec_q       <= '0;
      factor_q    <= DEC_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        factor_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Drive the cell row
  assign cell_ctrl.push    = do_push;
  assign cell_ctrl.rot     = (state_q == ST_RUN) && (cnt_q != CNT_LAST);
  assign cell_ctrl.wr      = do_write;
  assign cell_ctrl.wr_band = in_data_i.band_select;
  assign cell_ctrl.wr_coef = in_data_i.coef_value;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    assign sel[k] = (32'(in_data_i.tap_index) == k);
    tbfem_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .sel_i      (sel[k]),
      .push_smp_i ((k == 0) ? mix[SMP_W:1] : smp_w[(k + TAPS - 1) % TAPS]),
      .rot_smp_i  (smp_w[(k + 1) % TAPS]),
      .rot_coef_i (coef_w[(k + 1) % TAPS]),
      .smp_o      (smp_w[k]),
      .coef_o     (coef_w[k])
    );
  end

  // Band datapaths read the head cell
  for (genvar b = 0; b < NBANDS; b++) begin : g_band
    assign band_ctrl[b].clr_sum = fire;
    assign band_ctrl[b].mac_en  = cell_ctrl.rot;
    assign band_ctrl[b].add_en  = (state_q == ST_RUN) && (cnt_q != '0);
    assign band_ctrl[b].sqr_en  = (state_q == ST_SQR);
    assign band_ctrl[b].acc_en  = (state_q == ST_ADD);
    assign band_ctrl[b].rd_clr  = do_read && (32'(in_data_i.band_select) == b);
    tbfem_band #(
      .TAPS (TAPS)
    ) u_band (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (band_ctrl[b]),
      .coef_i (coef_w[0][b]),
      .smp_i  (smp_w[0]),
      .acc_o  (acc[b])
    );
  end

endmodule
